>>> src/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants and the command/status bundles that join the
// SHA-256 controller and datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned NumRounds = 64;
   localparam int unsigned NumWords  = 8;
   localparam int unsigned SchedLen  = 16;

   localparam logic [7:0] PadMark   = 8'h80;
   localparam logic [5:0] LenOffset = 6'd56;
   localparam logic [5:0] LastSlot  = 6'd63;

   localparam word_type RoundK [NumRounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitHash [NumWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Source of the byte shifted into the block window
   typedef enum logic [1:0] {
      BYTE_DATA = 2'd0,
      BYTE_MARK = 2'd1,
      BYTE_ZERO = 2'd2,
      BYTE_LEN  = 2'd3
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic         init_work;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         final_add;
      logic         load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       out_busy;
   } dp_status_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage
`default_nettype wire

>>> src/sha256_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_dp
// Block window / message schedule, working variables, chaining words, bit
// count and the digest output buffer.
// ----------------------------------------------------------------------------
module sha256_dp
   import sha256_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   input  wire logic [7:0]    byte_value,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,
   output logic               rsp_tlast
);

   word_type   sched_ff [SchedLen];
   word_type   sched_in [SchedLen];
   word_type   wk_ff [NumWords];
   word_type   wk_in [NumWords];
   word_type   hash_ff [NumWords];
   word_type   hash_in [NumWords];
   word_type   out_ff [NumWords];
   word_type   out_in [NumWords];
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  fill_ff, fill_in;
   logic [3:0]  out_cnt_ff, out_cnt_in;

   logic [7:0]  byte_in;
   logic [2:0]  len_idx;
   word_type    t1, t2, sched_new;
   logic        out_xfer;

   assign len_idx  = 3'd7 - fill_ff[2:0];
   assign out_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      case (cmd.byte_sel)
         BYTE_DATA: byte_in = byte_value;
         BYTE_MARK: byte_in = PadMark;
         BYTE_ZERO: byte_in = 8'h00;
         BYTE_LEN:  byte_in = bits_ff[{len_idx, 3'b000} +: 8];
         default:   byte_in = 8'h00;
      endcase
   end

   always_comb begin
      t1 = wk_ff[7] + big_sigma1(wk_ff[4])
         + ((wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]))
         + RoundK[cmd.round_idx] + sched_ff[0];
      t2 = big_sigma0(wk_ff[0])
         + ((wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]));
      sched_new = small_sigma1(sched_ff[14]) + sched_ff[9]
                + small_sigma0(sched_ff[1]) + sched_ff[0];
   end

   always_comb begin
      sched_in   = sched_ff;
      wk_in      = wk_ff;
      hash_in    = hash_ff;
      out_in     = out_ff;
      bits_in    = bits_ff;
      fill_in    = fill_ff;
      out_cnt_in = out_cnt_ff;

      // byte window: shift left by one byte, new byte at the bottom
      if (cmd.shift_en) begin
         for (int i = 0; i < SchedLen - 1; i++) begin
            sched_in[i] = {sched_ff[i][23:0], sched_ff[i+1][31:24]};
         end
         sched_in[SchedLen-1] = {sched_ff[SchedLen-1][23:0], byte_in};
         fill_in = fill_ff + 6'd1;
         if (cmd.byte_sel == BYTE_DATA) begin
            bits_in = bits_ff + 64'd8;
         end
      end

      if (cmd.init_work) begin
         wk_in = hash_ff;
      end

      // one round: advance working variables and schedule window
      if (cmd.round_en) begin
         wk_in[7] = wk_ff[6];
         wk_in[6] = wk_ff[5];
         wk_in[5] = wk_ff[4];
         wk_in[4] = wk_ff[3] + t1;
         wk_in[3] = wk_ff[2];
         wk_in[2] = wk_ff[1];
         wk_in[1] = wk_ff[0];
         wk_in[0] = t1 + t2;
         for (int i = 0; i < SchedLen - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[SchedLen-1] = sched_new;
      end

      if (cmd.final_add) begin
         for (int i = 0; i < NumWords; i++) begin
            hash_in[i] = hash_ff[i] + wk_ff[i];
         end
      end

      // drain the digest one word per transfer
      if (out_xfer) begin
         for (int i = 0; i < NumWords - 1; i++) begin
            out_in[i] = out_ff[i+1];
         end
         out_cnt_in = out_cnt_ff - 4'd1;
      end

      if (cmd.load_out) begin
         out_in     = hash_ff;
         out_cnt_in = 4'(NumWords);
         hash_in    = InitHash;
         bits_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff    <= InitHash;
         bits_ff    <= '0;
         fill_ff    <= '0;
         out_cnt_ff <= '0;
      end else begin
         hash_ff    <= hash_in;
         bits_ff    <= bits_in;
         fill_ff    <= fill_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      wk_ff    <= wk_in;
      out_ff   <= out_in;
   end

   assign status.fill     = fill_ff;
   assign status.out_busy = (out_cnt_ff != 4'd0);

   assign rsp_tvalid = (out_cnt_ff != 4'd0);
   assign rsp_tdata  = out_ff[0];
   assign rsp_tlast  = (out_cnt_ff == 4'd1);

endmodule
`default_nettype wire

>>> src/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte intake, padding, round counting and digest hand-off.
// ----------------------------------------------------------------------------
module sha256_ctrl
   import sha256_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic          byte_valid,
   input  wire logic          message_end,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_PAD_MARK = 8'b0000_0010,
      ST_PAD_ZERO = 8'b0000_0100,
      ST_PAD_LEN  = 8'b0000_1000,
      ST_START    = 8'b0001_0000,
      ST_COMP     = 8'b0010_0000,
      ST_FINISH   = 8'b0100_0000,
      ST_DIGEST   = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic       end_ff, end_in;
   logic       pad_ff, pad_in;
   logic       last_ff, last_in;
   logic       req_xfer;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      end_in   = end_ff;
      pad_in   = pad_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.byte_sel  = BYTE_DATA;
      cmd.round_idx = round_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               end_in = message_end;
               if (byte_valid) begin
                  cmd.shift_en = 1'b1;
               end
               if (byte_valid && status.fill == LastSlot) begin
                  state_in = ST_START;
               end else if (message_end) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_PAD_MARK: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BYTE_MARK;
            // mark placed: the close is now a padding run
            end_in = 1'b0;
            pad_in = 1'b1;
            state_in = (status.fill == LastSlot) ? ST_START : ST_PAD_ZERO;
         end
         ST_PAD_ZERO: begin
            if (status.fill == LenOffset) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = BYTE_ZERO;
               if (status.fill == LastSlot) begin
                  state_in = ST_START;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BYTE_LEN;
            if (status.fill == LastSlot) begin
               last_in  = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.init_work = 1'b1;
            round_in = '0;
            state_in = ST_COMP;
         end
         ST_COMP: begin
            cmd.round_en = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == LastSlot) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.final_add = 1'b1;
            if (last_ff) begin
               state_in = ST_DIGEST;
            end else if (pad_ff) begin
               state_in = ST_PAD_ZERO;
            end else if (end_ff) begin
               // close rode on the byte that filled the block
               state_in = ST_PAD_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIGEST: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               end_in   = 1'b0;
               pad_in   = 1'b0;
               last_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         end_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         end_ff   <= end_in;
         pad_ff   <= pad_in;
         last_ff  <= last_in;
      end
   end

   a_full_block_starts: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && byte_valid && status.fill == LastSlot) |=> state_ff == ST_START)
      else $error("full block did not start compression");

   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP && round_ff == LastSlot) |=> state_ff == ST_FINISH)
      else $error("compression did not finish after last round");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !status.out_busy)
      else $error("digest loaded over undrained output");

   a_len_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD_LEN) |-> status.fill >= LenOffset)
      else $error("length bytes outside the length field");

endmodule
`default_nettype wire

>>> src/sha256_message_digest.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 hashing engine: byte stream in, 256-bit digest out as eight words.
// ----------------------------------------------------------------------------
// Message bytes arrive one per transfer on the req_ channel and are shifted
// into a 64-byte block window. The 64th byte of a block starts compression,
// which occupies the engine (one load of the working variables, 64 rounds at
// one round per clock, one chaining add) before the next transfer is taken. A
// transfer with tlast high closes the message after taking its byte (if tuser
// marks one): the sequencer then shifts in the 0x80 mark, zeros and the 64-bit
// big-endian bit count at one byte per cycle and compresses one block, or two
// when fewer than nine bytes were free. The padding is longest when the mark
// lands in byte 56 and the length spills into a second block. The digest is
// copied into an eight-word output buffer, the chaining words reload the
// initial values, and a new message may stream in while the buffer drains on
// rsp_ (word 0 first, tlast on the eighth word). The load of a second digest
// waits until the previous digest has fully drained. A transfer with tuser low
// and tlast low is taken and changes nothing.
// ----------------------------------------------------------------------------
module sha256_message_digest
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tuser,   // [0] byte_valid
   input  wire logic        req_tlast,   // message_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] digest_word
   output logic             rsp_tlast    // word_last
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequence intake, padding and rounds
   sha256_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .byte_valid  (req_tuser),
      .message_end (req_tlast),
      .status      (status),
      .cmd         (cmd)
   );

   // Hold the block window, working state, chaining words and digest buffer
   sha256_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .byte_value (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> tb/tb_sha256_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_message_digest
// Self-checking bench for the SHA-256 byte-stream hashing engine.
// ----------------------------------------------------------------------------
// A queue of pending transfers feeds a clocked driver on the req_ channel.
// A clocked monitor hashes every accepted transfer in a local SHA-256 model
// and expects eight digest words for each closed message. The run opens with
// short directed messages: the empty string, a byte together with the close,
// a close on its own, and idle transfers. Random messages follow, grouped in
// phases with different sender and receiver idle rates. Message sizes rotate
// through short and medium lengths; one phase adds a long message (55..66
// bytes) whose length range spans padding overflow, an exactly full block and
// a spill into a second block. Idle transfers are mixed in as noise. Between
// phases the sender holds until every expected digest word has come back.
// ----------------------------------------------------------------------------
module tb_sha256_message_digest;

   localparam int unsigned HalfPeriod = 4;
   localparam int unsigned SettleCycles = 250;
   localparam int unsigned PhaseItems = 10;

   // SHA-256 round constants and initial hash values (FIPS 180-4)
   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HashSeed [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] MarkByte   = 8'h80;
   localparam int unsigned LenSlot   = 56;
   localparam int unsigned BlockSize = 64;

   // Message size classes
   typedef enum int unsigned {
      SIZE_SHORT,
      SIZE_MEDIUM,
      SIZE_LONG
   } msg_size_type;

   localparam msg_size_type SizeCycle [3] = '{
      SIZE_SHORT, SIZE_MEDIUM, SIZE_SHORT
   };

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       closes;
   } req_item_type;

   typedef struct packed {
      logic [31:0] value;
      logic        last;
   } digest_item_type;

   // DUT signals; every DUT input is at a known value from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] byte_value
   logic        req_tuser  = 1'b0;    // [0] byte_valid
   logic        req_tlast  = 1'b0;    // message_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] digest_word
   logic        rsp_tlast;            // word_last

   // Stimulus and scoreboard state
   req_item_type    pending_transfers [$];
   digest_item_type digests_due [$];
   req_item_type    next_transfer;
   digest_item_type oldest_due;
   logic            req_taken = 1'b0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     transfers_queued = 0;
   int unsigned     transfers_taken = 0;
   int unsigned     error_count = 0;

   // Local hash model state
   logic [31:0] chain_words [8];
   logic [7:0]  block_bytes [64];
   int unsigned block_fill;
   logic [63:0] bit_total;

   sha256_message_digest uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(HalfPeriod) clock = ~clock;

   // -------------------------------------------------------------------------
   // Hash model
   // -------------------------------------------------------------------------
   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds on the current block and fold into the chaining words.
   task automatic compress_block();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] t1, t2, s0, s1;
      int unsigned i;
      for (i = 0; i < 16; i++) begin
         sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                     block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      for (i = 16; i < 64; i++) begin
         s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
      end
      a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
      e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
      for (i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + RoundConst[i] + sched[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
      chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
   endtask

   task automatic restart_message();
      int unsigned i;
      for (i = 0; i < 8; i++) chain_words[i] = HashSeed[i];
      block_fill = 0;
      bit_total  = '0;
   endtask

   // Absorb one accepted transfer; a close pads, finishes and queues the digest.
   task automatic absorb_transfer(input logic [7:0] data, input logic has_byte,
                                  input logic closes);
      int unsigned idx;
      int unsigned i;
      digest_item_type item;
      if (has_byte) begin
         block_bytes[block_fill] = data;
         block_fill++;
         bit_total += 64'd8;
         if (block_fill == BlockSize) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (!closes) return;

      idx = block_fill;
      block_bytes[idx] = MarkByte;
      idx++;
      // fewer than nine free bytes: pad this block out and spill the length
      if (idx > LenSlot) begin
         while (idx < BlockSize) begin
            block_bytes[idx] = 8'h00;
            idx++;
         end
         compress_block();
         idx = 0;
      end
      while (idx < LenSlot) begin
         block_bytes[idx] = 8'h00;
         idx++;
      end
      for (i = 0; i < 8; i++) block_bytes[LenSlot + i] = bit_total[63 - 8*i -: 8];
      compress_block();

      for (i = 0; i < 8; i++) begin
         item.value = chain_words[i];
         item.last  = (i == 7);
         digests_due.push_back(item);
      end
      restart_message();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t ns: %s got %h expected %h", $time, what, got, want);
      error_count++;
   endtask

   // -------------------------------------------------------------------------
   // Driver: advance at the falling edge, hold an offered transfer until taken
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_transfers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_transfer = pending_transfers.pop_front();
            req_tdata  <= next_transfer.data;
            req_tuser  <= next_transfer.has_byte;
            req_tlast  <= next_transfer.closes;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         restart_message();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digests_due.size() == 0) begin
               report_mismatch("unexpected digest transfer", rsp_tdata, 32'h0);
            end else begin
               oldest_due = digests_due.pop_front();
               if (rsp_tdata !== oldest_due.value)
                  report_mismatch("digest_word", rsp_tdata, oldest_due.value);
               if (rsp_tlast !== oldest_due.last)
                  report_mismatch("word_last", {31'b0, rsp_tlast}, {31'b0, oldest_due.last});
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_transfer(req_tdata, req_tuser, req_tlast);
            transfers_taken++;
         end
         req_taken <= req_tvalid && req_tready;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   task automatic queue_transfer(input logic [7:0] data, input logic has_byte,
                                 input logic closes);
      req_item_type item;
      item.data     = data;
      item.has_byte = has_byte;
      item.closes   = closes;
      pending_transfers.push_back(item);
      transfers_queued++;
   endtask

   // Idle transfer with random content; it must change nothing.
   task automatic queue_noise();
      queue_transfer(8'($urandom_range(255)), 1'b0, 1'b0);
   endtask

   // Queue one message of msg_len random bytes; the close rides on the last
   // byte or follows on its own.
   task automatic queue_message(input int unsigned msg_len, input bit close_on_byte);
      int unsigned i;
      for (i = 0; i < msg_len; i++) begin
         if ($urandom_range(99) < 8) queue_noise();
         queue_transfer(8'($urandom_range(255)), 1'b1, close_on_byte && (i == msg_len - 1));
      end
      if (!close_on_byte || msg_len == 0) queue_transfer(8'h00, 1'b0, 1'b1);
   endtask

   function automatic int unsigned pick_length(input msg_size_type size_class);
      case (size_class)
         SIZE_SHORT:  return $urandom_range(6);
         SIZE_MEDIUM: return $urandom_range(20, 7);
         default:     return $urandom_range(66, 55);
      endcase
   endfunction

   // Hold the sender until all transfers are taken and every digest is back.
   task automatic drain();
      while (transfers_taken != transfers_queued) @(negedge clock);
      while (digests_due.size() != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input bit with_long, inout int unsigned msg_serial);
      int unsigned start_queued;
      int unsigned msg_len;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start_queued   = transfers_queued;
      if (with_long) begin
         msg_len = pick_length(SIZE_LONG);
         queue_message(msg_len, $urandom_range(1) == 1);
      end
      while (transfers_queued - start_queued < PhaseItems) begin
         msg_len = pick_length(SizeCycle[msg_serial % 3]);
         queue_message(msg_len, msg_len != 0 && $urandom_range(1) == 1);
         if ($urandom_range(3) == 0) queue_noise();
         msg_serial++;
      end
      drain();
   endtask

   initial begin
      int unsigned msg_serial;
      msg_serial = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty message, idle transfers, byte with close, "abc",
      // close after a byte, extreme byte values, back-to-back closes.
      queue_transfer(8'hff, 1'b0, 1'b1);
      queue_transfer(8'h5a, 1'b0, 1'b0);
      queue_transfer(8'h00, 1'b1, 1'b1);
      queue_transfer(8'h61, 1'b1, 1'b0);
      queue_transfer(8'h62, 1'b1, 1'b0);
      queue_transfer(8'h63, 1'b1, 1'b1);
      queue_transfer(8'hff, 1'b1, 1'b0);
      queue_transfer(8'hff, 1'b0, 1'b0);
      queue_transfer(8'h00, 1'b0, 1'b1);
      queue_transfer(8'h00, 1'b0, 1'b1);
      queue_transfer(8'hff, 1'b1, 1'b1);
      queue_transfer(8'h00, 1'b1, 1'b0);
      queue_transfer(8'hff, 1'b1, 1'b0);
      queue_transfer(8'ha5, 1'b1, 1'b1);
      drain();

      // Random messages under each idle pattern
      run_phase(0, 0, 1'b0, msg_serial);
      run_phase(71, 0, 1'b0, msg_serial);
      run_phase(0, 71, 1'b0, msg_serial);
      run_phase(19, 19, 1'b1, msg_serial);

      // Catch any stray digest words after the last expected one
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("TIMEOUT: run did not finish");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
src/sha256_pkg.sv
src/sha256_dp.sv
src/sha256_ctrl.sv
src/sha256_message_digest.sv
tb/tb_sha256_message_digest.sv
